@@ design/asp_pkg.sv @@
// Shared types and constants for the ADT segment stream parser.
`timescale 1ns / 1ps

package asp_pkg;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [7:0] CHAR_PIPE = 8'h7C;
    localparam logic [7:0] CHAR_CR   = 8'h0D;
    localparam logic [7:0] CHAR_LF   = 8'h0A;
    localparam logic [7:0] CHAR_V    = 8'h56;

    localparam logic [2:0] SEG_MSH = 3'd0;
    localparam logic [2:0] SEG_EVN = 3'd1;
    localparam logic [2:0] SEG_PID = 3'd2;
    localparam logic [2:0] SEG_PD1 = 3'd3;
    localparam logic [2:0] SEG_PV1 = 3'd4;

    typedef enum logic [3:0] {
        PH_TAG_MSH = 4'd0,
        PH_TAG_EVN = 4'd1,
        PH_TAG_PID = 4'd2,
        PH_TAG_OPT = 4'd3,
        PH_TAG_PV1 = 4'd4,
        PH_FLD_MSH = 4'd5,
        PH_FLD_EVN = 4'd6,
        PH_FLD_PID = 4'd7,
        PH_FLD_PD1 = 4'd8,
        PH_FLD_PV1 = 4'd9,
        PH_EOL_MSH = 4'd10,
        PH_EOL_EVN = 4'd11,
        PH_EOL_PID = 4'd12,
        PH_EOL_PD1 = 4'd13,
        PH_EOL_PV1 = 4'd14,
        PH_DONE    = 4'd15
    } phase_t;

    typedef enum logic [1:0] {
        ST_PENDING = 2'd0,
        ST_ACCEPT  = 2'd1,
        ST_REJECT  = 2'd2
    } status_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       is_eol;
        logic       is_pipe;
        logic       is_text;
    } class_word_t;

    typedef struct packed {
        logic       text_valid;
        logic [6:0] text_byte;
        logic       field_start;
        logic [2:0] segment;
        logic [5:0] field_number;
        logic [1:0] status;
    } result_word_t;

    function automatic logic [7:0] tag_char(input logic [2:0] seg, input logic [1:0] pos);
        logic [7:0] c;
        c = 8'h00;
        case (seg)
            SEG_MSH: c = (pos == 2'd0) ? 8'h4D : (pos == 2'd1) ? 8'h53 : 8'h48;
            SEG_EVN: c = (pos == 2'd0) ? 8'h45 : (pos == 2'd1) ? 8'h56 : 8'h4E;
            SEG_PID: c = (pos == 2'd0) ? 8'h50 : (pos == 2'd1) ? 8'h49 : 8'h44;
            SEG_PD1: c = (pos == 2'd0) ? 8'h50 : (pos == 2'd1) ? 8'h44 : 8'h31;
            SEG_PV1: c = (pos == 2'd0) ? 8'h50 : (pos == 2'd1) ? 8'h56 : 8'h31;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

@@ design/asp_front.sv @@
// Front end: classifies each incoming byte into a word for the parser.
`timescale 1ns / 1ps

module asp_front
(
    input  logic [7:0]          data_byte,
    input  logic                last,
    output asp_pkg::class_word_t word
);

    always_comb
    begin
        word.data    = data_byte;
        word.last    = last;
        word.is_eol  = (data_byte == asp_pkg::CHAR_CR) || (data_byte == asp_pkg::CHAR_LF);
        word.is_pipe = (data_byte == asp_pkg::CHAR_PIPE);
        word.is_text = (data_byte >= 8'h20) && (data_byte <= 8'h7E)
                       && (data_byte != asp_pkg::CHAR_PIPE);
    end

endmodule

@@ design/asp_queue.sv @@
// Small register queue used between pipeline parts.
`timescale 1ns / 1ps

module asp_queue #(
    parameter type word_t = logic,
    parameter int  DEPTH  = 2
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  word_t wdata,
    output logic  full,
    input  logic  pop,
    output word_t rdata,
    output logic  empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    word_t          mem_reg [DEPTH];
    logic [PW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  count_reg, count_next;
    logic           wr_en, rd_en;

    assign full  = (count_reg == CW'(DEPTH));
    assign empty = (count_reg == '0);
    assign wr_en = push && !full;
    assign rd_en = pop && !empty;
    assign rdata = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

@@ design/asp_back.sv @@
// Back end: segment/field state machine producing one result word per byte.
`timescale 1ns / 1ps

module asp_back #(
    parameter logic [5:0] FIELD_LIMIT = 6'd63
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  asp_pkg::class_word_t  in_word,
    output logic                  in_take,
    input  logic                  out_room,
    output logic                  out_push,
    output asp_pkg::result_word_t out_word
);

    asp_pkg::phase_t  phase_reg, phase_next, phase_step;
    asp_pkg::status_t outcome_reg, outcome_next, outcome_step, status_final;
    logic [1:0]       tag_pos_reg, tag_pos_next, tag_pos_step;
    logic             inside_reg, inside_next, inside_step;
    logic [5:0]       field_cnt_reg, field_cnt_next, field_cnt_step;

    logic       fire;
    logic       in_tag, in_fld, eol_mode;
    logic [2:0] seg_idx;
    logic       fld_eol, fld_pipe, fld_text, fld_end;
    logic       pend;
    logic [2:0] tag_ph;
    logic [1:0] tag_pos;
    logic       pv_hit, tag_hit;
    logic [5:0] field_cnt_inc;
    logic       early;

    assign fire     = in_valid && out_room;
    assign in_take  = fire;
    assign out_push = fire;

    assign in_tag   = (phase_reg <= asp_pkg::PH_TAG_PV1);
    assign in_fld   = !in_tag && (phase_reg != asp_pkg::PH_DONE);
    assign eol_mode = in_fld && (phase_reg >= asp_pkg::PH_EOL_MSH);
    assign seg_idx  = eol_mode ? 3'(4'(phase_reg) - 4'd10) : 3'(4'(phase_reg) - 4'd5);

    assign fld_eol  = in_fld && in_word.is_eol;
    assign fld_pipe = in_fld && !eol_mode && in_word.is_pipe;
    assign fld_text = in_fld && !eol_mode && inside_reg && in_word.is_text;
    assign fld_end  = in_fld && !fld_eol && !fld_pipe && !fld_text;

    assign pend    = in_tag || (fld_end && (seg_idx != asp_pkg::SEG_PV1));
    assign tag_ph  = in_tag ? 3'(phase_reg) : seg_idx + 3'd1;
    assign tag_pos = (in_tag && tag_pos_reg != 2'd3) ? tag_pos_reg : 2'd0;
    assign pv_hit  = (tag_ph == asp_pkg::SEG_PD1) && (tag_pos == 2'd1)
                     && (in_word.data == asp_pkg::CHAR_V);
    assign tag_hit = (in_word.data == asp_pkg::tag_char(tag_ph, tag_pos));

    assign field_cnt_inc = !inside_reg ? 6'd0 :
                           (field_cnt_reg < FIELD_LIMIT) ? field_cnt_reg + 6'd1 : field_cnt_reg;

    always_comb
    begin
        phase_step     = phase_reg;
        outcome_step   = outcome_reg;
        tag_pos_step   = tag_pos_reg;
        inside_step    = inside_reg;
        field_cnt_step = field_cnt_reg;
        if (fld_eol)
        begin
            phase_step = asp_pkg::phase_t'(4'd10 + 4'(seg_idx));
        end
        else if (fld_pipe)
        begin
            field_cnt_step = field_cnt_inc;
            inside_step    = 1'b1;
        end
        else if (fld_end && !pend)
        begin
            outcome_step = asp_pkg::ST_ACCEPT;
            phase_step   = asp_pkg::PH_DONE;
        end
        if (pend)
        begin
            if (!in_tag)
            begin
                phase_step     = asp_pkg::phase_t'(4'(tag_ph));
                tag_pos_step   = 2'd0;
                inside_step    = 1'b0;
                field_cnt_step = 6'd0;
            end
            if (pv_hit)
            begin
                phase_step   = asp_pkg::PH_TAG_PV1;
                tag_pos_step = 2'd2;
            end
            else if (tag_hit)
            begin
                if (tag_pos == 2'd2)
                begin
                    phase_step     = asp_pkg::phase_t'(4'd5 + 4'(tag_ph));
                    tag_pos_step   = 2'd0;
                    inside_step    = 1'b0;
                    field_cnt_step = 6'd0;
                end
                else
                begin
                    tag_pos_step = tag_pos + 2'd1;
                end
            end
            else
            begin
                outcome_step = (tag_ph <= asp_pkg::SEG_PID) ? asp_pkg::ST_REJECT
                                                            : asp_pkg::ST_ACCEPT;
                phase_step   = asp_pkg::PH_DONE;
            end
        end
    end

    assign early = (phase_step <= asp_pkg::PH_TAG_PID) || (phase_step == asp_pkg::PH_FLD_MSH)
                   || (phase_step == asp_pkg::PH_FLD_EVN) || (phase_step == asp_pkg::PH_EOL_MSH)
                   || (phase_step == asp_pkg::PH_EOL_EVN);

    always_comb
    begin
        status_final = outcome_step;
        if (in_word.last && outcome_step == asp_pkg::ST_PENDING)
        begin
            status_final = early ? asp_pkg::ST_REJECT : asp_pkg::ST_ACCEPT;
        end
    end

    // next state
    always_comb
    begin
        phase_next     = phase_reg;
        outcome_next   = outcome_reg;
        tag_pos_next   = tag_pos_reg;
        inside_next    = inside_reg;
        field_cnt_next = field_cnt_reg;
        if (fire)
        begin
            if (in_word.last)
            begin
                phase_next     = asp_pkg::PH_TAG_MSH;
                outcome_next   = asp_pkg::ST_PENDING;
                tag_pos_next   = 2'd0;
                inside_next    = 1'b0;
                field_cnt_next = 6'd0;
            end
            else
            begin
                phase_next     = phase_step;
                outcome_next   = outcome_step;
                tag_pos_next   = tag_pos_step;
                inside_next    = inside_step;
                field_cnt_next = field_cnt_step;
            end
        end
    end

    // outputs
    always_comb
    begin
        out_word              = '0;
        out_word.status       = status_final;
        if (in_fld)
        begin
            out_word.segment      = seg_idx;
            out_word.field_number = field_cnt_reg;
        end
        if (fld_pipe)
        begin
            out_word.field_start  = 1'b1;
            out_word.field_number = field_cnt_inc;
        end
        if (fld_text)
        begin
            out_word.text_valid = 1'b1;
            out_word.text_byte  = in_word.data[6:0];
        end
        if (pend)
        begin
            out_word.segment      = pv_hit ? asp_pkg::SEG_PV1 : tag_ph;
            out_word.field_number = 6'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= asp_pkg::PH_TAG_MSH;
            outcome_reg   <= asp_pkg::ST_PENDING;
            tag_pos_reg   <= 2'd0;
            inside_reg    <= 1'b0;
            field_cnt_reg <= 6'd0;
        end
        else
        begin
            phase_reg     <= phase_next;
            outcome_reg   <= outcome_next;
            tag_pos_reg   <= tag_pos_next;
            inside_reg    <= inside_next;
            field_cnt_reg <= field_cnt_next;
        end
    end

    a_last_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        fire && in_word.last |=> phase_reg == asp_pkg::PH_TAG_MSH
                                 && outcome_reg == asp_pkg::ST_PENDING)
        else $error("message end did not restart parser");

    a_done_decided: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == asp_pkg::PH_DONE |-> outcome_reg != asp_pkg::ST_PENDING)
        else $error("done without a decided status");

    a_field_cap: assert property (@(posedge clk) disable iff (!rst_n)
        field_cnt_reg <= FIELD_LIMIT)
        else $error("field counter past limit");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !fire |=> $stable(phase_reg) && $stable(field_cnt_reg))
        else $error("parser state moved without a word");

endmodule

@@ design/adt_segment_stream_parser_core.sv @@
// Top level of the ADT segment stream parser.
`timescale 1ns / 1ps

// Takes one message byte per cycle while the input queue is not full, and
// returns one result word per byte, in order. A pushed byte is registered in
// the input queue, then its result word in the output queue, before it reaches
// the result ports. The rate is one byte per cycle when nothing stalls, set by
// the back end's state update. Two-word queues after the classifier and parser
// let either side stall, until a queue fills, without stopping the other.
// The last byte's word carries the final status; the parser then starts over.
module adt_segment_stream_parser_core #(
    parameter int MAX_FIELDS = 64
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] data_byte,
    input  logic       last,
    input  logic       pop,
    output logic       empty,
    output logic       text_valid,
    output logic [6:0] text_byte,
    output logic       field_start,
    output logic [2:0] segment,
    output logic [5:0] field_number,
    output logic [1:0] status
);

    localparam logic [5:0] FIELD_LIMIT = (MAX_FIELDS - 1 > 63) ? 6'd63 : 6'(MAX_FIELDS - 1);

    asp_pkg::class_word_t  front_word, mid_word;
    asp_pkg::result_word_t back_word, res_word;
    logic                  mid_empty, mid_take;
    logic                  out_full, out_push;

    asp_front u_front
    (
        .data_byte (data_byte),
        .last      (last),
        .word      (front_word)
    );

    asp_queue #(
        .word_t (asp_pkg::class_word_t),
        .DEPTH  (asp_pkg::QUEUE_DEPTH)
    ) u_mid_queue
    (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (front_word),
        .full  (full),
        .pop   (mid_take),
        .rdata (mid_word),
        .empty (mid_empty)
    );

    asp_back #(
        .FIELD_LIMIT (FIELD_LIMIT)
    ) u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (!mid_empty),
        .in_word  (mid_word),
        .in_take  (mid_take),
        .out_room (!out_full),
        .out_push (out_push),
        .out_word (back_word)
    );

    asp_queue #(
        .word_t (asp_pkg::result_word_t),
        .DEPTH  (asp_pkg::QUEUE_DEPTH)
    ) u_out_queue
    (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (out_push),
        .wdata (back_word),
        .full  (out_full),
        .pop   (pop),
        .rdata (res_word),
        .empty (empty)
    );

    assign text_valid   = res_word.text_valid;
    assign text_byte    = res_word.text_byte;
    assign field_start  = res_word.field_start;
    assign segment      = res_word.segment;
    assign field_number = res_word.field_number;
    assign status       = res_word.status;

endmodule
